>>> src/temt_pkg.sv
`default_nettype none

package temt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned IdW      = 32;
  localparam int unsigned HashW    = 32;
  localparam int unsigned TimeoutW = 16;

  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd3000;

  // byte address of the timeout register
  localparam logic [1:0] TIMEOUT_ADDR = 2'd0;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_QUERY_ID = 2'd1,
    MODE_QUERY_HS = 2'd2
  } mode_e;

  // request travelling down the row of cells, one cell per cycle
  typedef struct packed {
    logic             active;
    logic [1:0]       mode;
    logic [TimeW-1:0] now;
    logic [IdW-1:0]   id;
    logic [HashW-1:0] hash;
    logic             found;
    logic             placed;
  } token_t;

endpackage

`default_nettype wire

>>> src/timed_event_membership_table.sv
// channel   | direction | handshake                 | payload
// s_axis    | in        | tvalid / tready           | mode, now_ms, event_id, event_hash
// m_axis    | out       | tvalid / tready           | found, full_drop
// apb       | in        | psel, penable, pwrite     | timeout_ms at address 0
//
// an accepted word walks the row of TABLE_DEPTH cells, one cell per cycle;
// each cell expires its entry, then inserts or compares as the word passes
// the result passes from the last cell into the output register, or into the holding register if stalled;
// the next word is taken once that result is in the output register, not before
// reset clears all valid bits and sets timeout_ms to 3000
// a result stalled at the output waits in a one-entry holding register;
// one word is in the row at a time, input ready is low while it walks
`default_nettype none

module timed_event_membership_table (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // s_axis_tdata_i: mode[1:0], now_ms[33:2], event_id[65:34], event_hash[97:66], zeros
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [103:0] s_axis_tdata_i,
  // m_axis_tdata_o: found[0], full_drop[1], zeros
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [1:0]   paddr_i,
  input  wire logic [31:0]  pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  localparam int unsigned Depth = temt_pkg::TABLE_DEPTH;

  logic [temt_pkg::TimeoutW-1:0] timeout_q;
  logic                          busy_q, busy_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_found_q, out_found_d;
  logic                          out_drop_q, out_drop_d;
  logic                          pend_valid_q, pend_valid_d;
  logic                          pend_found_q, pend_found_d;
  logic                          pend_drop_q, pend_drop_d;

  temt_pkg::token_t              chain [Depth+1];
  logic [Depth-1:0]              chain_active;

  logic in_take, out_take, out_free;
  logic res_valid, res_found, res_drop;
  logic cfg_wr;

  // configuration
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i == temt_pkg::TIMEOUT_ADDR);
  assign prdata_o = (paddr_i == temt_pkg::TIMEOUT_ADDR) ?
                    {{(32-temt_pkg::TimeoutW){1'b0}}, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= temt_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_q <= pwdata_i[temt_pkg::TimeoutW-1:0];
    end
  end

  // input
  assign s_axis_tready_o = !busy_q;
  assign in_take         = s_axis_tvalid_i && !busy_q;

  always_comb begin
    chain[0].active = in_take;
    chain[0].mode   = s_axis_tdata_i[1:0];
    chain[0].now    = s_axis_tdata_i[33:2];
    chain[0].id     = s_axis_tdata_i[65:34];
    chain[0].hash   = s_axis_tdata_i[97:66];
    chain[0].found  = 1'b0;
    chain[0].placed = 1'b0;
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    temt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .timeout_i (timeout_q),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1])
    );
    assign chain_active[g] = chain[g+1].active;
  end

  // result leaving the row
  assign res_valid = chain[Depth].active;
  assign res_found = chain[Depth].found;
  assign res_drop  = (chain[Depth].mode == temt_pkg::MODE_INSERT) && !chain[Depth].placed;

  assign out_take = out_valid_q && m_axis_tready_i;
  assign out_free = !out_valid_q || out_take;

  always_comb begin
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_drop_d   = out_drop_q;
    pend_valid_d = pend_valid_q;
    pend_found_d = pend_found_q;
    pend_drop_d  = pend_drop_q;
    if (in_take) begin
      busy_d = 1'b1;
    end
    if (out_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_found_d  = pend_found_q;
        out_drop_d   = pend_drop_q;
        pend_valid_d = 1'b0;
        busy_d       = 1'b0;
      end else if (res_valid) begin
        out_valid_d = 1'b1;
        out_found_d = res_found;
        out_drop_d  = res_drop;
        busy_d      = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      pend_valid_d = 1'b1;
      pend_found_d = res_found;
      pend_drop_d  = res_drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_drop_q   <= out_drop_d;
    pend_found_q <= pend_found_d;
    pend_drop_q  <= pend_drop_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_drop_q, out_found_q};

  // checks
  a_one_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_active) <= 1)
    else $error("more than one word in the cell row");

  a_idle_row_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (chain_active == '0) && !pend_valid_q)
    else $error("row or holding register busy while input is ready");

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("holding register full while output register is empty");

  a_take_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> busy_q && chain_active[0])
    else $error("accepted word did not enter the row");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_found_q && out_drop_q))
    else $error("found and full_drop both set");

endmodule

`default_nettype wire

>>> src/temt_cell.sv
`default_nettype none

module temt_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [temt_pkg::TimeoutW-1:0]  timeout_i,
  input  wire temt_pkg::token_t               tok_i,
  output temt_pkg::token_t                    tok_o
);

  logic                        valid_q, valid_d;
  logic [temt_pkg::TimeW-1:0]  stamp_q;
  logic [temt_pkg::IdW-1:0]    id_q;
  logic [temt_pkg::HashW-1:0]  hash_q;
  temt_pkg::token_t            tok_q, tok_d;

  logic [temt_pkg::TimeW-1:0]  age;
  logic                        live;
  logic                        match;
  logic                        take;

  assign age  = tok_i.now - stamp_q;
  assign live = valid_q &&
                (age < {{(temt_pkg::TimeW-temt_pkg::TimeoutW){1'b0}}, timeout_i});

  always_comb begin
    case (tok_i.mode)
      temt_pkg::MODE_QUERY_ID: match = live && (id_q == tok_i.id);
      temt_pkg::MODE_QUERY_HS: match = live && (hash_q == tok_i.hash);
      default:                 match = 1'b0;
    endcase
  end

  // lowest free slot wins: the first free cell the token meets
  assign take = tok_i.active && !tok_i.placed && !live &&
                (tok_i.mode == temt_pkg::MODE_INSERT);

  always_comb begin
    valid_d = valid_q;
    tok_d   = tok_i;
    if (tok_i.active) begin
      valid_d      = live || take;
      tok_d.placed = tok_i.placed || take;
      tok_d.found  = tok_i.found || match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stamp_q <= tok_i.now;
      id_q    <= tok_i.id;
      hash_q  <= tok_i.hash;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
